@@ src/fepsq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fepsq_pkg
// Shared types, codes and sizes of the flash erase / program sequencer.
// ----------------------------------------------------------------------------
package fepsq_pkg;

  // Unit sizes in bytes
  localparam logic [31:0] SECTOR_BYTES  = 32'd4096;
  localparam logic [31:0] PROGRAM_BYTES = 32'd8;

  // Reset value of the flash base address register
  localparam logic [31:0] BASE_RESET = 32'h0800_0000;

  // Input item kinds
  localparam logic [1:0] KIND_START_ERASE   = 2'd0;
  localparam logic [1:0] KIND_START_PROGRAM = 2'd1;
  localparam logic [1:0] KIND_OP_END        = 2'd2;

  // Configuration register indexes
  localparam logic CFG_FLASH_BASE     = 1'b0;
  localparam logic CFG_NOTIFY_ENABLED = 1'b1;

  typedef enum logic [1:0] {
    ACT_ERASE   = 2'd0,
    ACT_PROGRAM = 2'd1,
    ACT_FINISH  = 2'd2,
    ACT_IDLE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    EVT_NONE       = 2'd0,
    EVT_ERASE_DONE = 2'd1,
    EVT_PROG_DONE  = 2'd2,
    EVT_ERROR      = 2'd3
  } event_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] source_addr;
    logic        has_error;
    logic [31:0] status_bits;
  } item_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] flash_addr;
    logic [31:0] data_addr;
    logic [31:0] range_start;
    logic [31:0] range_size;
    logic        notify;
    event_t      event_kind;
    logic [31:0] event_status;
  } result_t;

  // Handshake between the input register, the core and the output register
  typedef struct packed {
    logic item_valid;
    logic res_ready;
  } flow_t;

endpackage

@@ src/flash_erase_program_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_erase_program_sequencer_top
// Sequences multi-sector erase and double-word program runs of a flash.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries start-erase, start-program
//   and operation-end transactions. Every accepted transaction yields exactly
//   one result transaction on the output channel (out_valid / out_stall):
//   the next erase or program command, a finish report, or an idle code.
//   Configuration (base address, notify enable) is written through
//   cfg_write / cfg_index / cfg_data while no transaction is in flight.
//   An accepted transaction waits in the input register; its result is loaded
//   into the result register once it has room: one transaction per cycle while
//   out_stall is low. The run-state update is a single add and compare between
//   the two registers, so back-to-back transactions see each other's state.
//   Reset (rst, synchronous) empties both registers, clears the run state and
//   restores the base address to 0x0800_0000 with notifications off.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more transaction, then in_stall rises until space frees.
// ----------------------------------------------------------------------------
module flash_erase_program_sequencer_top
  import fepsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] offset,
  input  logic [31:0] size,
  input  logic [31:0] source_addr,
  input  logic        has_error,
  input  logic [31:0] status_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  action,
  output logic [31:0] flash_addr,
  output logic [31:0] data_addr,
  output logic [31:0] range_start,
  output logic [31:0] range_size,
  output logic        notify,
  output logic [1:0]  event_kind,
  output logic [31:0] event_status
);

  item_t   in_item;
  item_t   item;
  result_t res_next;
  result_t res;
  flow_t   flow;
  logic    step;

  // Pack input fields
  assign in_item.kind        = kind;
  assign in_item.offset      = offset;
  assign in_item.size        = size;
  assign in_item.source_addr = source_addr;
  assign in_item.has_error   = has_error;
  assign in_item.status_bits = status_bits;

  // Move an item when the result register has room
  assign step = flow.item_valid && flow.res_ready;

  fepsq_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_take  (step),
    .item_valid (flow.item_valid),
    .item       (item)
  );

  fepsq_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .step      (step),
    .result    (res_next)
  );

  fepsq_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_load  (flow.item_valid),
    .res_in    (res_next),
    .res_ready (flow.res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_out   (res)
  );

  // Unpack result fields
  assign action       = res.action;
  assign flash_addr   = res.flash_addr;
  assign data_addr    = res.data_addr;
  assign range_start  = res.range_start;
  assign range_size   = res.range_size;
  assign notify       = res.notify;
  assign event_kind   = res.event_kind;
  assign event_status = res.event_status;

endmodule

@@ src/fepsq_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fepsq_in_reg
// Input register: captures one transaction and holds it until the core
// takes it.
// ----------------------------------------------------------------------------
module fepsq_in_reg
  import fepsq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  item_take,
  output logic  item_valid,
  output item_t item
);

  // Stall only while a held item cannot leave this cycle
  assign in_stall = item_valid && !item_take;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_item;
    end
  end

endmodule

@@ src/fepsq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fepsq_core
// Run state, configuration registers and the single-pass next-result logic.
// ----------------------------------------------------------------------------
module fepsq_core
  import fepsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  item_t       item,
  input  logic        step,
  output result_t     result
);

  logic [31:0] flash_base;
  logic        notify_enabled;
  logic        program_mode;
  logic [31:0] current_offset;
  logic [31:0] remaining_bytes;
  logic [31:0] current_source;
  logic [31:0] start_offset;
  logic [31:0] start_size;

  logic        program_mode_next;
  logic [31:0] current_offset_next;
  logic [31:0] remaining_bytes_next;
  logic [31:0] current_source_next;
  logic [31:0] start_offset_next;
  logic [31:0] start_size_next;

  logic [31:0] start_unit;
  logic [31:0] run_unit;
  logic [31:0] rem_step;
  logic [31:0] off_step;
  logic [31:0] src_step;

  // Unit sizes for a new run and for the active run
  assign start_unit = (item.kind == KIND_START_PROGRAM) ? PROGRAM_BYTES : SECTOR_BYTES;
  assign run_unit   = program_mode ? PROGRAM_BYTES : SECTOR_BYTES;

  // Advance by one unit, partial tail counts as full
  assign rem_step = (remaining_bytes > run_unit) ? (remaining_bytes - run_unit) : 32'd0;
  assign off_step = current_offset + run_unit;
  assign src_step = program_mode ? (current_source + run_unit) : current_source;

  // Decode the item against the run state
  always_comb begin
    program_mode_next    = program_mode;
    current_offset_next  = current_offset;
    remaining_bytes_next = remaining_bytes;
    current_source_next  = current_source;
    start_offset_next    = start_offset;
    start_size_next      = start_size;

    result.action       = ACT_IDLE;
    result.flash_addr   = '0;
    result.data_addr    = '0;
    result.range_start  = '0;
    result.range_size   = '0;
    result.notify       = 1'b0;
    result.event_kind   = EVT_NONE;
    result.event_status = '0;

    priority if (item.kind == KIND_START_ERASE || item.kind == KIND_START_PROGRAM) begin
      // Start a new run, replacing any active one
      program_mode_next    = (item.kind == KIND_START_PROGRAM);
      current_offset_next  = item.offset;
      start_offset_next    = item.offset;
      start_size_next      = item.size;
      remaining_bytes_next = (item.size < start_unit) ? start_unit : item.size;
      current_source_next  = item.source_addr;
      result.action        = (item.kind == KIND_START_PROGRAM) ? ACT_PROGRAM : ACT_ERASE;
      result.flash_addr    = flash_base + item.offset;
      if (item.kind == KIND_START_PROGRAM) begin
        result.data_addr = item.source_addr;
      end
    end else if (item.kind == KIND_OP_END && remaining_bytes != 32'd0) begin
      if (item.has_error) begin
        // Abort the run and pass the status on
        remaining_bytes_next = '0;
        result.action        = ACT_FINISH;
        result.range_start   = flash_base + start_offset;
        result.range_size    = start_size;
        result.notify        = notify_enabled;
        result.event_kind    = EVT_ERROR;
        result.event_status  = item.status_bits;
      end else begin
        remaining_bytes_next = rem_step;
        current_offset_next  = off_step;
        current_source_next  = src_step;
        if (rem_step != 32'd0) begin
          // Issue the next command
          result.action     = program_mode ? ACT_PROGRAM : ACT_ERASE;
          result.flash_addr = flash_base + off_step;
          if (program_mode) begin
            result.data_addr = src_step;
          end
        end else begin
          // Report the whole range
          result.action       = ACT_FINISH;
          result.range_start  = flash_base + start_offset;
          result.range_size   = start_size;
          result.event_status = item.status_bits;
          if (program_mode) begin
            result.event_kind = EVT_PROG_DONE;
            result.notify     = notify_enabled;
          end else begin
            result.event_kind = EVT_ERASE_DONE;
            result.notify     = notify_enabled && (item.status_bits != 32'd0);
          end
        end
      end
    end else begin
      // End event while idle or unused kind: no action
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base     <= BASE_RESET;
      notify_enabled <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FLASH_BASE:     flash_base     <= cfg_data;
        CFG_NOTIFY_ENABLED: notify_enabled <= cfg_data[0];
        default:            flash_base     <= flash_base;
      endcase
    end
  end

  // Run state, updated as each item moves to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_mode    <= 1'b0;
      current_offset  <= '0;
      remaining_bytes <= '0;
      current_source  <= '0;
      start_offset    <= '0;
      start_size      <= '0;
    end else if (step) begin
      program_mode    <= program_mode_next;
      current_offset  <= current_offset_next;
      remaining_bytes <= remaining_bytes_next;
      current_source  <= current_source_next;
      start_offset    <= start_offset_next;
      start_size      <= start_size_next;
    end
  end

endmodule

@@ src/fepsq_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fepsq_out_reg
// Result register: holds one result transaction until the receiver takes it.
// ----------------------------------------------------------------------------
module fepsq_out_reg
  import fepsq_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_load,
  input  result_t res_in,
  output logic    res_ready,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t res_out
);

  // Free when empty or being drained this cycle
  assign res_ready = !out_valid || !out_stall;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (res_ready && res_load) begin
      res_out <= res_in;
    end
  end

endmodule

@@ tb/sv/flash_sequencer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_sequencer_checker
// Watches the configuration port and both channels of the flash erase /
// program sequencer, predicts the command for every accepted transaction and
// compares each accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
module flash_sequencer_checker
  import fepsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] offset,
  input  logic [31:0] size,
  input  logic [31:0] source_addr,
  input  logic        has_error,
  input  logic [31:0] status_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  action,
  input  logic [31:0] flash_addr,
  input  logic [31:0] data_addr,
  input  logic [31:0] range_start,
  input  logic [31:0] range_size,
  input  logic        notify,
  input  logic [1:0]  event_kind,
  input  logic [31:0] event_status,
  output int unsigned mismatch_count,
  output int unsigned pending_results
);

  // Shadow registers and run state
  logic [31:0] base_addr;
  logic        notify_en;
  logic        prog_mode;
  logic [31:0] cur_offset;
  logic [31:0] bytes_left;
  logic [31:0] cur_source;
  logic [31:0] run_offset;
  logic [31:0] run_size;

  result_t expected_commands[$];

  // Close the run and build the finish report
  function automatic result_t finish_run(event_t evt, logic wants_note,
                                         logic [31:0] status);
    result_t r;
    r = '0;
    r.action       = ACT_FINISH;
    r.range_start  = base_addr + run_offset;
    r.range_size   = run_size;
    r.notify       = wants_note && notify_en;
    r.event_kind   = evt;
    r.event_status = status;
    bytes_left     = '0;
    return r;
  endfunction

  // Advance the run state by one transaction and return the expected command
  function automatic result_t predict_command(item_t txn);
    result_t     r;
    logic [31:0] unit;
    r = '0;
    r.action     = ACT_IDLE;
    r.event_kind = EVT_NONE;
    if (txn.kind == KIND_START_ERASE || txn.kind == KIND_START_PROGRAM) begin
      prog_mode  = (txn.kind == KIND_START_PROGRAM);
      unit       = prog_mode ? PROGRAM_BYTES : SECTOR_BYTES;
      cur_offset = txn.offset;
      run_offset = txn.offset;
      run_size   = txn.size;
      bytes_left = (txn.size < unit) ? unit : txn.size;
      cur_source = txn.source_addr;
      r.action     = prog_mode ? ACT_PROGRAM : ACT_ERASE;
      r.flash_addr = base_addr + txn.offset;
      if (prog_mode) r.data_addr = txn.source_addr;
    end else if (txn.kind == KIND_OP_END && bytes_left != '0) begin
      if (txn.has_error) begin
        r = finish_run(EVT_ERROR, 1'b1, txn.status_bits);
      end else begin
        unit       = prog_mode ? PROGRAM_BYTES : SECTOR_BYTES;
        bytes_left = (bytes_left > unit) ? bytes_left - unit : '0;
        cur_offset = cur_offset + unit;
        if (prog_mode) cur_source = cur_source + unit;
        if (bytes_left != '0) begin
          r.action     = prog_mode ? ACT_PROGRAM : ACT_ERASE;
          r.flash_addr = base_addr + cur_offset;
          if (prog_mode) r.data_addr = cur_source;
        end else if (prog_mode) begin
          r = finish_run(EVT_PROG_DONE, 1'b1, txn.status_bits);
        end else begin
          r = finish_run(EVT_ERASE_DONE, txn.status_bits != '0, txn.status_bits);
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %08h, actual %08h", $time, field, want_v, got_v);
      mismatch_count++;
    end
  endtask

  // Track config, retire results, then queue predictions
  always @(posedge clk) begin
    result_t want;
    item_t   txn;
    if (rst) begin
      expected_commands.delete();
      mismatch_count = 0;
      base_addr  = BASE_RESET;
      notify_en  = 1'b0;
      prog_mode  = 1'b0;
      cur_offset = '0;
      bytes_left = '0;
      cur_source = '0;
      run_offset = '0;
      run_size   = '0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_FLASH_BASE) base_addr = cfg_data;
        else notify_en = cfg_data[0];
      end
      if (out_valid && !out_stall) begin
        if (expected_commands.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual action %0d addr %08h",
                   $time, action, flash_addr);
          mismatch_count++;
        end else begin
          want = expected_commands.pop_front();
          check_field("action", 32'(want.action), 32'(action));
          check_field("flash_addr", want.flash_addr, flash_addr);
          check_field("data_addr", want.data_addr, data_addr);
          check_field("range_start", want.range_start, range_start);
          check_field("range_size", want.range_size, range_size);
          check_field("notify", 32'(want.notify), 32'(notify));
          check_field("event_kind", 32'(want.event_kind), 32'(event_kind));
          check_field("event_status", want.event_status, event_status);
        end
      end
      if (in_valid && !in_stall) begin
        txn.kind        = kind;
        txn.offset      = offset;
        txn.size        = size;
        txn.source_addr = source_addr;
        txn.has_error   = has_error;
        txn.status_bits = status_bits;
        expected_commands.push_back(predict_command(txn));
      end
    end
    pending_results = expected_commands.size();
  end

endmodule

@@ tb/sv/tb_flash_erase_program_sequencer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flash_erase_program_sequencer_top
// Drives erase and program runs into the sequencer: a directed pass over the
// corner cases, then random runs under several idle and stall mixes and
// register settings. The checker predicts and compares; this module decides.
// ----------------------------------------------------------------------------
module tb_flash_erase_program_sequencer_top;
  import fepsq_pkg::*;

  localparam logic [1:0]  KIND_UNUSED   = 2'd3;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASE_RUNS    = 106;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst         = 1'b1;
  logic        cfg_write   = 1'b0;
  logic        cfg_index   = 1'b0;
  logic [31:0] cfg_data    = '0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  logic [1:0]  kind        = '0;
  logic [31:0] offset      = '0;
  logic [31:0] size        = '0;
  logic [31:0] source_addr = '0;
  logic        has_error   = 1'b0;
  logic [31:0] status_bits = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  logic [1:0]  action;
  logic [31:0] flash_addr;
  logic [31:0] data_addr;
  logic [31:0] range_start;
  logic [31:0] range_size;
  logic        notify;
  logic [1:0]  event_kind;
  logic [31:0] event_status;

  int unsigned mismatch_count;
  int unsigned pending_results;
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;

  flash_erase_program_sequencer_top dut (.*);
  flash_sequencer_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Randomly stall the result channel
  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Drop the run if no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one transaction, hold it until accepted
  task automatic send_txn(logic [1:0] k, logic [31:0] off, logic [31:0] sz,
                          logic [31:0] src, logic err, logic [31:0] st);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= k;
    offset      <= off;
    size        <= sz;
    source_addr <= src;
    has_error   <= err;
    status_bits <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_end(logic err, logic [31:0] st);
    send_txn(KIND_OP_END, $urandom(), $urandom(), $urandom(), err, st);
  endtask

  // Pause input until every result has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_status();
    return ($urandom_range(3) == 0) ? 32'd0 : $urandom();
  endfunction

  // One run: a start, its end events, sometimes cut short by an error or a restart
  task automatic run_one_sequence(inout int unsigned counted);
    logic            prog;
    logic            big;
    logic [31:0]     unit;
    logic [31:0]     sz;
    longint unsigned units;
    int unsigned     ends;
    int unsigned     i;
    prog = 1'($urandom_range(1));
    big  = ($urandom_range(7) == 0);
    unit = prog ? PROGRAM_BYTES : SECTOR_BYTES;
    sz   = big ? $urandom() : $urandom_range(prog ? 72 : 5 * 4096 + 100);
    send_txn(prog ? KIND_START_PROGRAM : KIND_START_ERASE, $urandom(), sz, $urandom(),
             1'($urandom_range(1)), $urandom());
    counted++;
    units = (sz <= unit) ? 1 : ({32'd0, sz} + unit - 1) / unit;
    if (big) ends = $urandom_range(3);
    else if ($urandom_range(9) == 0) ends = $urandom_range(32'(units));
    else ends = 32'(units);
    for (i = 0; i < ends; i++) begin
      if ($urandom_range(14) == 0) begin
        send_end(1'b1, $urandom());
        counted++;
        return;
      end
      send_end(1'b0, random_status());
      counted++;
    end
    if (big && $urandom_range(1)) begin
      send_end(1'b1, $urandom());
      counted++;
    end
    // trailing end event that lands on an idle sequencer
    if (!big && ends == units && $urandom_range(4) == 0) begin
      send_end(1'($urandom_range(1)), $urandom());
    end
  endtask

  task automatic run_random_phase(int unsigned target);
    int unsigned counted;
    counted = 0;
    while (counted < target) begin
      if ($urandom_range(9) == 0) begin
        send_txn($urandom_range(1) ? KIND_UNUSED : KIND_OP_END, $urandom(), $urandom(),
                 $urandom(), 1'($urandom_range(1)), $urandom());
      end else begin
        run_one_sequence(counted);
      end
      if ($urandom_range(39) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  initial begin
    int unsigned phase;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: idle events, unused kind, small size, misaligned runs
    send_txn(KIND_OP_END, 32'd0, 32'd0, 32'd0, 1'b1, ALL_ONES);
    send_txn(KIND_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES);
    send_txn(KIND_START_ERASE, 32'd0, 32'd0, 32'd0, 1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    send_txn(KIND_START_PROGRAM, 32'h0000_0123, 32'd20, 32'hFFFF_FFF8, 1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    send_end(1'b0, 32'h0000_00A5);
    send_txn(KIND_START_ERASE, 32'h0000_1000, 32'h0000_2001, 32'd0, 1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    send_txn(KIND_START_PROGRAM, ALL_ONES, 32'd8, 32'd0, 1'b0, 32'd0);
    send_end(1'b0, 32'd7);
    send_txn(KIND_START_ERASE, 32'h0001_0000, 32'h0000_2000, 32'd0, 1'b0, 32'd0);
    send_end(1'b1, 32'h8000_0001);
    wait_results_drained();

    // Wrapping base with notifications on
    write_reg(CFG_NOTIFY_ENABLED, 32'd1);
    write_reg(CFG_FLASH_BASE, ALL_ONES);
    send_txn(KIND_START_ERASE, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES);
    send_end(1'b1, ALL_ONES);
    send_txn(KIND_START_ERASE, 32'd0, 32'd4096, 32'd0, 1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    send_txn(KIND_START_ERASE, 32'h0000_2000, 32'd1, 32'd0, 1'b0, 32'd0);
    send_end(1'b0, 32'd1);
    send_txn(KIND_START_PROGRAM, 32'd0, 32'd0, ALL_ONES, 1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    send_end(1'b0, 32'd0);
    wait_results_drained();

    // Random runs: no idling, sender idle, receiver stall, both lightly
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          write_reg(CFG_FLASH_BASE, $urandom());
          write_reg(CFG_NOTIFY_ENABLED, 32'd1);
        end
        1: begin
          idle_pct = 85; stall_pct = 0;
          write_reg(CFG_FLASH_BASE, 32'd0);
          write_reg(CFG_NOTIFY_ENABLED, 32'd0);
        end
        2: begin
          idle_pct = 0;  stall_pct = 85;
          write_reg(CFG_FLASH_BASE, BASE_RESET);
          write_reg(CFG_NOTIFY_ENABLED, 32'd1);
        end
        default: begin
          idle_pct = 9;  stall_pct = 9;
          write_reg(CFG_FLASH_BASE, $urandom());
          write_reg(CFG_NOTIFY_ENABLED, $urandom_range(1));
        end
      endcase
      run_random_phase(PHASE_RUNS);
    end

    // Let the pipeline settle, then decide
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fepsq_pkg.sv
src/fepsq_in_reg.sv
src/fepsq_core.sv
src/fepsq_out_reg.sv
src/flash_erase_program_sequencer_top.sv
tb/sv/flash_sequencer_checker.sv
tb/sv/tb_flash_erase_program_sequencer_top.sv
